>>> hdl/hpwm_pkg.sv
package hpwm_pkg;

  // Field and register widths.
  localparam int CLK_W      = 29;
  localparam int FREQ_W     = 20;
  localparam int SPD_W      = 16;
  localparam int VAL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 29;
  localparam int MAG_W      = 7;
  localparam int PROD_W     = MAG_W + VAL_W;
  localparam int DIV_CNT_W  = 5;
  localparam int RECIP_W    = 24;
  localparam int PCT_SHIFT  = 30;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_FREQ    = 2'd1;

  // Reset values.
  localparam logic [CLK_W-1:0]  CLK_RESET  = 29'd84000000;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 20'd1000;
  localparam logic [VAL_W-1:0]  MAX16      = 16'hFFFF;

  // Speed handling constants.
  localparam logic signed [SPD_W-1:0] SPD_FULL_POS = 16'sd100;
  localparam logic signed [SPD_W-1:0] SPD_FULL_NEG = -16'sd100;
  localparam logic [MAG_W-1:0]        SPD_CLAMP    = 7'd99;
  // Rounded-up reciprocal of 100 scaled by 2^PCT_SHIFT.
  localparam logic [RECIP_W-1:0]      PCT_RECIP    = 24'd10737419;

  // Input action codes.
  localparam logic ACT_SPEED = 1'b0;
  localparam logic ACT_BRAKE = 1'b1;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_SEL_QUOT  = 2'd0,
    DIV_SEL_TICK  = 2'd1,
    DIV_SEL_RATIO = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     load_psc;
    logic     load_arr;
    logic     set_err;
    logic     load_prod;
    logic     load_duty;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic timing_valid;
    logic cfg_zero;
    logic brake;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/hpwm_in_if.sv
interface hpwm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic signed [hpwm_pkg::SPD_W-1:0]      speed;

  modport source (output valid, output action, output speed, input ready);
  modport sink (input valid, input action, input speed, output ready);
endinterface

>>> hdl/hpwm_out_if.sv
interface hpwm_out_if;
  logic                        valid;
  logic                        ready;
  logic [hpwm_pkg::VAL_W-1:0]  compare_a;
  logic [hpwm_pkg::VAL_W-1:0]  compare_b;
  logic [hpwm_pkg::VAL_W-1:0]  prescaler_value;
  logic [hpwm_pkg::VAL_W-1:0]  period_value;
  logic                        freq_error;

  modport source (output valid, output compare_a, output compare_b, output prescaler_value,
                  output period_value, output freq_error, input ready);
  modport sink (input valid, input compare_a, input compare_b, input prescaler_value,
                input period_value, input freq_error, output ready);
endinterface

>>> hdl/hbridge_pwm_duty_setup.sv
// With current timing, a speed request passes the check, multiply and duty states before
// its result is loaded, and a brake goes from the check straight to its result. The duty
// comes from a multiply and a reciprocal multiply for the division by 100. The first
// request after reset or a register write adds three passes of the shared radix-2 divider
// for prescaler and period. One request is in work at a time; a busy output holds it.
// Reset (synchronous, rst_n low) restores the settings and timing and forces re-derivation.
module hbridge_pwm_duty_setup (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hpwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpwm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  hpwm_in_if.sink                          in_chan,
  hpwm_out_if.source                       out_chan
);

  hpwm_pkg::ctrl_cmd_t cmd;
  hpwm_pkg::dp_stat_t  stat;

  hpwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hpwm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_action           (in_chan.action),
    .in_speed            (in_chan.speed),
    .out_ready           (out_chan.ready),
    .out_valid           (out_chan.valid),
    .out_compare_a       (out_chan.compare_a),
    .out_compare_b       (out_chan.compare_b),
    .out_prescaler_value (out_chan.prescaler_value),
    .out_period_value    (out_chan.period_value),
    .out_freq_error      (out_chan.freq_error),
    .cmd                 (cmd),
    .stat                (stat)
  );

endmodule

>>> hdl/hpwm_div.sv
module hpwm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hpwm_pkg::CLK_W-1:0]    dividend,
  input  logic [hpwm_pkg::FREQ_W-1:0]   divisor,
  output logic [hpwm_pkg::CLK_W-1:0]    quotient,
  output logic                          done
);

  logic [hpwm_pkg::CLK_W-1:0]     dq_r, dq_nxt;
  logic [hpwm_pkg::FREQ_W-1:0]    rem_r, rem_nxt;
  logic [hpwm_pkg::FREQ_W-1:0]    dvs_r, dvs_nxt;
  logic [hpwm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [hpwm_pkg::FREQ_W:0]      rem_sh;
  logic [hpwm_pkg::FREQ_W:0]      rem_sub;
  logic                           ge;

  // Restoring division: the dividend shifts out at the top while the
  // quotient bits shift in at the bottom of the same register.
  always_comb begin
    rem_sh  = {rem_r, dq_r[hpwm_pkg::CLK_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});

    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = hpwm_pkg::DIV_CNT_W'(hpwm_pkg::CLK_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[hpwm_pkg::CLK_W-2:0], ge};
      rem_nxt = ge ? rem_sub[hpwm_pkg::FREQ_W-1:0] : rem_sh[hpwm_pkg::FREQ_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == hpwm_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = dq_r;
  assign done     = done_r;

endmodule

>>> hdl/hpwm_dp.sv
module hpwm_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hpwm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpwm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_action,
  input  logic signed [hpwm_pkg::SPD_W-1:0]    in_speed,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [hpwm_pkg::VAL_W-1:0]           out_compare_a,
  output logic [hpwm_pkg::VAL_W-1:0]           out_compare_b,
  output logic [hpwm_pkg::VAL_W-1:0]           out_prescaler_value,
  output logic [hpwm_pkg::VAL_W-1:0]           out_period_value,
  output logic                                 out_freq_error,
  input  hpwm_pkg::ctrl_cmd_t                  cmd,
  output hpwm_pkg::dp_stat_t                   stat
);

  logic [hpwm_pkg::CLK_W-1:0]          clk_hz_r;
  logic [hpwm_pkg::FREQ_W-1:0]         freq_r;
  logic [hpwm_pkg::VAL_W-1:0]          psc_r;
  logic [hpwm_pkg::VAL_W-1:0]          per_r;
  logic                                valid_r;
  logic                                err_r;
  logic                                action_r;
  logic signed [hpwm_pkg::SPD_W-1:0]   speed_r;
  logic [hpwm_pkg::PROD_W-1:0]         prod_r;
  logic [hpwm_pkg::VAL_W-1:0]          duty_r;
  logic                                oval_r, oval_nxt;
  logic [hpwm_pkg::VAL_W-1:0]          oca_r, ocb_r, opsc_r, oper_r;
  logic                                oerr_r;

  logic [hpwm_pkg::CLK_W-1:0]          quo;
  logic                                div_done;
  logic [hpwm_pkg::CLK_W-1:0]          dvd;
  logic [hpwm_pkg::FREQ_W-1:0]         dvs;
  logic [hpwm_pkg::CLK_W-1:0]          quo_m1;
  logic [hpwm_pkg::CLK_W-1:0]          psc_full;
  logic [hpwm_pkg::VAL_W-1:0]          psc_calc;
  logic [hpwm_pkg::VAL_W-1:0]          arr_calc;
  logic [hpwm_pkg::VAL_W:0]            psc_inc;
  logic signed [hpwm_pkg::SPD_W-1:0]   spd_abs;
  logic [hpwm_pkg::MAG_W-1:0]          mag;
  logic [hpwm_pkg::PROD_W-1:0]         prod_calc;
  logic                                spd_pos;
  logic [hpwm_pkg::PROD_W+hpwm_pkg::RECIP_W-1:0] duty_wide;
  logic [hpwm_pkg::VAL_W-1:0]          duty_calc;

  hpwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quo),
    .done     (div_done)
  );

  // Prescaler is the first quotient minus one, and the period is the
  // ratio minus one; a zero ratio wraps and saturates to full scale.
  always_comb begin
    quo_m1   = quo - 1'b1;
    psc_full = (quo == '0) ? '0 : quo_m1;
    psc_calc = (|psc_full[hpwm_pkg::CLK_W-1:hpwm_pkg::VAL_W]) ? hpwm_pkg::MAX16
                                                               : psc_full[hpwm_pkg::VAL_W-1:0];
    if (quo == '0 || (|quo_m1[hpwm_pkg::CLK_W-1:hpwm_pkg::VAL_W])) begin
      arr_calc = hpwm_pkg::MAX16;
    end else begin
      arr_calc = quo_m1[hpwm_pkg::VAL_W-1:0];
    end
    psc_inc = {1'b0, psc_calc} + 1'b1;
  end

  // clock / (f * 65536) equals (clock >> 16) / f, which keeps the
  // product out of the divider entirely.
  always_comb begin
    case (cmd.div_sel)
      hpwm_pkg::DIV_SEL_QUOT: begin
        dvd = hpwm_pkg::CLK_W'(clk_hz_r[hpwm_pkg::CLK_W-1:16]);
        dvs = freq_r;
      end
      hpwm_pkg::DIV_SEL_TICK: begin
        dvd = clk_hz_r;
        dvs = hpwm_pkg::FREQ_W'(psc_inc);
      end
      hpwm_pkg::DIV_SEL_RATIO: begin
        dvd = quo;
        dvs = freq_r;
      end
      default: begin
        dvd = clk_hz_r;
        dvs = freq_r;
      end
    endcase
  end

  always_comb begin
    spd_abs = speed_r[hpwm_pkg::SPD_W-1] ? -speed_r : speed_r;
    if (speed_r > hpwm_pkg::SPD_FULL_POS || speed_r < hpwm_pkg::SPD_FULL_NEG) begin
      mag = hpwm_pkg::SPD_CLAMP;
    end else begin
      mag = spd_abs[hpwm_pkg::MAG_W-1:0];
    end
    prod_calc = {{hpwm_pkg::VAL_W{1'b0}}, mag} * {{hpwm_pkg::MAG_W{1'b0}}, per_r};
    spd_pos   = !speed_r[hpwm_pkg::SPD_W-1] && (speed_r != '0);
  end

  // The product stays below 2^23, so the rounded-up reciprocal of 100
  // gives the exact floor of the division after the shift.
  always_comb begin
    duty_wide = {{hpwm_pkg::RECIP_W{1'b0}}, prod_r} *
                {{hpwm_pkg::PROD_W{1'b0}}, hpwm_pkg::PCT_RECIP};
    duty_calc = duty_wide[hpwm_pkg::PCT_SHIFT +: hpwm_pkg::VAL_W];
  end

  always_comb begin
    oval_nxt = oval_r;
    if (cmd.load_out) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= hpwm_pkg::CLK_RESET;
      freq_r   <= hpwm_pkg::FREQ_RESET;
      psc_r    <= '0;
      per_r    <= hpwm_pkg::MAX16;
      valid_r  <= 1'b0;
      err_r    <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
      if (cfg_we && cfg_index == hpwm_pkg::CFG_TIMER_CLOCK) begin
        clk_hz_r <= cfg_wdata;
        valid_r  <= 1'b0;
      end else if (cfg_we && cfg_index == hpwm_pkg::CFG_PWM_FREQ) begin
        freq_r  <= cfg_wdata[hpwm_pkg::FREQ_W-1:0];
        valid_r <= 1'b0;
      end else if (cmd.set_err) begin
        err_r   <= 1'b1;
        valid_r <= 1'b1;
      end else if (cmd.load_arr) begin
        per_r   <= arr_calc;
        err_r   <= 1'b0;
        valid_r <= 1'b1;
      end
      if (cmd.load_psc) begin
        psc_r <= psc_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action_r <= in_action;
      speed_r  <= in_speed;
    end
    if (cmd.load_prod) begin
      prod_r <= prod_calc;
    end
    if (cmd.load_duty) begin
      duty_r <= duty_calc;
    end
    if (cmd.load_out) begin
      if (action_r == hpwm_pkg::ACT_BRAKE) begin
        oca_r <= per_r;
        ocb_r <= per_r;
      end else begin
        oca_r <= spd_pos ? duty_r : '0;
        ocb_r <= spd_pos ? '0 : duty_r;
      end
      opsc_r <= psc_r;
      oper_r <= per_r;
      oerr_r <= err_r;
    end
  end

  assign stat.timing_valid = valid_r;
  assign stat.cfg_zero     = (freq_r == '0) || (clk_hz_r == '0);
  assign stat.brake        = (action_r == hpwm_pkg::ACT_BRAKE);
  assign stat.div_done     = div_done;
  assign stat.out_free     = !oval_r || out_ready;

  assign out_valid           = oval_r;
  assign out_compare_a       = oca_r;
  assign out_compare_b       = ocb_r;
  assign out_prescaler_value = opsc_r;
  assign out_period_value    = oper_r;
  assign out_freq_error      = oerr_r;

endmodule

>>> hdl/hpwm_ctrl.sv
module hpwm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hpwm_pkg::dp_stat_t   stat,
  output hpwm_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_CHECK  = 8'b00000010,
    S_Q_WAIT = 8'b00000100,
    S_T_WAIT = 8'b00001000,
    S_R_WAIT = 8'b00010000,
    S_MUL    = 8'b00100000,
    S_DUTY   = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = hpwm_pkg::DIV_SEL_QUOT;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.timing_valid || stat.cfg_zero) begin
          // A zero clock or frequency keeps the old timing and flags it.
          cmd.set_err = !stat.timing_valid;
          state_nxt   = stat.brake ? S_DONE : S_MUL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = hpwm_pkg::DIV_SEL_QUOT;
          state_nxt     = S_Q_WAIT;
        end
      end
      S_Q_WAIT: begin
        cmd.div_sel = hpwm_pkg::DIV_SEL_TICK;
        if (stat.div_done) begin
          cmd.load_psc  = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_T_WAIT;
        end
      end
      S_T_WAIT: begin
        cmd.div_sel = hpwm_pkg::DIV_SEL_RATIO;
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_R_WAIT;
        end
      end
      S_R_WAIT: begin
        if (stat.div_done) begin
          cmd.load_arr = 1'b1;
          state_nxt    = stat.brake ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd.load_prod = 1'b1;
        state_nxt     = S_DUTY;
      end
      S_DUTY: begin
        cmd.load_duty = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
